// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL files that carry checks.
// They sample on the rising edge of clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that is switched off while arst_n is low.
`define ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that holds at every edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/dtp_pkg.sv =====
`timescale 1ns / 1ps

package dtp_pkg;

	// Field widths.
	localparam int unsigned CHAR_W  = 8;
	localparam int unsigned YEAR_W  = 14;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned DAY_W   = 5;
	localparam int unsigned DAYS_W  = 22;

	// Parser state widths.
	localparam int unsigned POS_W = 4;
	localparam int unsigned ACC_W = 7;

	// Positions within the text.
	localparam logic [POS_W-1:0] POS_YEAR_END  = 4'd4;
	localparam logic [POS_W-1:0] POS_DASH_A    = 4'd4;
	localparam logic [POS_W-1:0] POS_DASH_B    = 4'd7;
	localparam logic [POS_W-1:0] POS_MONTH_LO  = 4'd5;
	localparam logic [POS_W-1:0] POS_MONTH_HI  = 4'd6;
	localparam logic [POS_W-1:0] POS_DAY_LO    = 4'd8;
	localparam logic [POS_W-1:0] POS_DAY_HI    = 4'd9;
	localparam logic [POS_W-1:0] TEXT_LEN      = 4'd10;
	localparam logic [POS_W-1:0] POS_SAT       = 4'd11;

	// Character codes.
	localparam logic [CHAR_W-1:0] CHAR_DASH = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

	// Calendar constants.
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
	localparam logic [DAY_W-1:0]   DAY_MAX   = 5'd31;
	localparam int unsigned EPOCH_YEAR    = 1971;
	localparam int unsigned DAYS_PER_YEAR = 365;
	// Leap years among 1..1970: 1970/4 - 1970/100 + 1970/400.
	localparam int unsigned LEAPS_BEFORE_EPOCH = 1970 / 4 - 1970 / 100 + 1970 / 400;

	// Division by 100 as a reciprocal multiply, exact for every 14-bit year below 10000.
	localparam int unsigned DIV100_MUL   = 5243;
	localparam int unsigned DIV100_SHIFT = 19;
	localparam int unsigned PROD_W       = 27;
	localparam int unsigned QUOT_W       = 7;
	localparam int unsigned CENTURY      = 100;

	// Width of the leap count and the month offset.
	localparam int unsigned LEAP_W = 12;
	localparam int unsigned MOFF_W = 9;

	// One date on its way to the day count.
	typedef struct packed {
		logic                ok;
		logic [YEAR_W-1:0]   year;
		logic [MONTH_W-1:0]  month;
		logic [DAY_W-1:0]    day;
	} date_t;

	// Length of a month in a common year.
	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
		logic [DAY_W-1:0] len;
		case (m)
			4'd2:    len = 5'd28;
			4'd4:    len = 5'd30;
			4'd6:    len = 5'd30;
			4'd9:    len = 5'd30;
			4'd11:   len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

	// Days in a common year before the first of a month.
	function automatic logic [MOFF_W-1:0] month_start(input logic [MONTH_W-1:0] m);
		logic [MOFF_W-1:0] off;
		case (m)
			4'd2:    off = 9'd31;
			4'd3:    off = 9'd59;
			4'd4:    off = 9'd90;
			4'd5:    off = 9'd120;
			4'd6:    off = 9'd151;
			4'd7:    off = 9'd181;
			4'd8:    off = 9'd212;
			4'd9:    off = 9'd243;
			4'd10:   off = 9'd273;
			4'd11:   off = 9'd304;
			4'd12:   off = 9'd334;
			default: off = 9'd0;
		endcase
		return off;
	endfunction

endpackage

// ===== hdl/date_text_parse_day_count_unit.sv =====
// Date text parser: one character transfer per cycle while s_tready is high, no gaps between texts.
// The result leaves from stage s4 once the transfer that carries tlast has passed registered stages s1 to s4.
// Throughput: one character per cycle while s_tready is high; results leave through a four-stage pipeline.
// The input stalls only when every pipeline stage holds a result and m_tready is low.
// Reset (arst_n low) clears the character position, the failure flag,
// the accumulators and all stage valid bits.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module date_text_parse_day_count_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	input  logic        s_tlast,   // end_of_text
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [13:0] year_value, [17:14] month_value,
	                               // [22:18] day_value, [44:23] days_since_epoch, [47:45] zero
	output logic        m_tuser    // valid_res
);

	logic           accept;
	logic           fin_valid;
	dtp_pkg::date_t fin_date;
	dtp_pkg::date_t out_date;
	logic [dtp_pkg::DAYS_W-1:0] out_days;

	assign accept = s_tvalid && s_tready;

	// Character parser.
	dtp_parse u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.char_code   (s_tdata),
		.end_of_text (s_tlast),
		.fin_valid   (fin_valid),
		.fin_date    (fin_date)
	);

	// Calendar check and day count.
	dtp_days u_days (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fin_valid),
		.in_ready  (s_tready),
		.in_date   (fin_date),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_date  (out_date),
		.out_days  (out_days)
	);

	// Pack the result fields.
	assign m_tdata = {3'b000, out_days, out_date.day, out_date.month, out_date.year};
	assign m_tuser = out_date.ok;

	// An invalid result carries only zeros.
	`ASSERT_RST(a_invalid_zero, (m_tvalid && !m_tuser) |-> (m_tdata == 48'd0), "invalid result with nonzero fields")
	// A valid result has a real month and a nonzero day.
	`ASSERT_RST(a_valid_range, (m_tvalid && m_tuser) |-> ((m_tdata[17:14] >= 4'd1) && (m_tdata[17:14] <= 4'd12) && (m_tdata[22:18] != 5'd0)), "valid result out of range")
	// The input stalls only behind a full pipeline held by the output.
	`ASSERT_RST(a_stall_source, !s_tready |-> (m_tvalid && !m_tready), "input stalled without output backpressure")
	// Nothing leaves right after reset is released.
	`ASSERT_ALWAYS(a_reset_empty, $rose(arst_n) |-> (!m_tvalid && s_tready), "pipeline not empty after reset")

endmodule

// ===== hdl/dtp_parse.sv =====
`timescale 1ns / 1ps

module dtp_parse (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [dtp_pkg::CHAR_W-1:0]    char_code,
	input  logic                          end_of_text,
	output logic                          fin_valid,
	output dtp_pkg::date_t                fin_date
);

	logic [dtp_pkg::POS_W-1:0]  pos_q;
	logic                       fail_q;
	logic [dtp_pkg::YEAR_W-1:0] year_q;
	logic [dtp_pkg::ACC_W-1:0]  month_q;
	logic [dtp_pkg::ACC_W-1:0]  day_q;

	logic [dtp_pkg::POS_W-1:0]  pos_n;
	logic                       fail_n;
	logic [dtp_pkg::YEAR_W-1:0] year_n;
	logic [dtp_pkg::ACC_W-1:0]  month_n;
	logic [dtp_pkg::ACC_W-1:0]  day_n;
	logic                       digit;
	logic                       dash_pos;
	logic                       in_text;
	logic [3:0]                 dv;

	// Classify the character against its position and fold digits in decimal.
	always_comb begin
		digit    = (char_code >= dtp_pkg::CHAR_ZERO) && (char_code <= dtp_pkg::CHAR_NINE);
		dv       = digit ? char_code[3:0] : 4'd0;
		dash_pos = (pos_q == dtp_pkg::POS_DASH_A) || (pos_q == dtp_pkg::POS_DASH_B);
		in_text  = pos_q < dtp_pkg::TEXT_LEN;

		fail_n = fail_q
			|| !in_text
			|| (dash_pos && (char_code != dtp_pkg::CHAR_DASH))
			|| (in_text && !dash_pos && !digit);

		year_n  = year_q;
		month_n = month_q;
		day_n   = day_q;
		if (digit && (pos_q < dtp_pkg::POS_YEAR_END)) begin
			year_n = year_q * dtp_pkg::YEAR_W'(10) + dtp_pkg::YEAR_W'(dv);
		end
		if (digit && ((pos_q == dtp_pkg::POS_MONTH_LO) || (pos_q == dtp_pkg::POS_MONTH_HI))) begin
			month_n = month_q * dtp_pkg::ACC_W'(10) + dtp_pkg::ACC_W'(dv);
		end
		if (digit && ((pos_q == dtp_pkg::POS_DAY_LO) || (pos_q == dtp_pkg::POS_DAY_HI))) begin
			day_n = day_q * dtp_pkg::ACC_W'(10) + dtp_pkg::ACC_W'(dv);
		end

		pos_n = (pos_q < dtp_pkg::POS_SAT) ? pos_q + dtp_pkg::POS_W'(1) : dtp_pkg::POS_SAT;
	end

	// Finished date, checked except for the day bound of each month, which needs the leap rule.
	always_comb begin
		fin_valid      = accept && end_of_text;
		fin_date.ok    = !fail_n
			&& (pos_n == dtp_pkg::TEXT_LEN)
			&& (month_n >= dtp_pkg::ACC_W'(1))
			&& (month_n <= dtp_pkg::ACC_W'(dtp_pkg::MONTH_DEC))
			&& (day_n >= dtp_pkg::ACC_W'(1))
			&& (day_n <= dtp_pkg::ACC_W'(dtp_pkg::DAY_MAX));
		fin_date.year  = year_n;
		fin_date.month = month_n[dtp_pkg::MONTH_W-1:0];
		fin_date.day   = day_n[dtp_pkg::DAY_W-1:0];
	end

	// Parser state; the end mark returns everything to the start of a new text.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			fail_q  <= 1'b0;
			year_q  <= '0;
			month_q <= '0;
			day_q   <= '0;
		end else if (accept) begin
			if (end_of_text) begin
				pos_q   <= '0;
				fail_q  <= 1'b0;
				year_q  <= '0;
				month_q <= '0;
				day_q   <= '0;
			end else begin
				pos_q   <= pos_n;
				fail_q  <= fail_n;
				year_q  <= year_n;
				month_q <= month_n;
				day_q   <= day_n;
			end
		end
	end

endmodule

// ===== hdl/dtp_days.sv =====
`timescale 1ns / 1ps

module dtp_days (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  dtp_pkg::date_t                in_date,
	output logic                          out_valid,
	input  logic                          out_ready,
	output dtp_pkg::date_t                out_date,
	output logic [dtp_pkg::DAYS_W-1:0]    out_days
);

	logic v1_s1, v2_s2, v3_s3, v4_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	dtp_pkg::date_t date_s1, date_s2, date_s3, date_s4;
	logic [dtp_pkg::QUOT_W-1:0]  quot_s2;
	logic [dtp_pkg::DAYS_W-1:0]  ybase_s3;
	logic [dtp_pkg::LEAP_W-1:0]  leaps_s3;
	logic [dtp_pkg::MOFF_W-1:0]  moff_s3;
	logic [dtp_pkg::DAYS_W-1:0]  days_s4;

	logic [dtp_pkg::PROD_W-1:0]  prod;
	logic [dtp_pkg::YEAR_W-1:0]  cent_mul;
	logic                        rem_zero;
	logic                        leap;
	logic [dtp_pkg::QUOT_W-1:0]  quot_prev;
	logic [dtp_pkg::YEAR_W-1:0]  year_prev;
	logic                        after_epoch;
	logic [dtp_pkg::DAY_W-1:0]   dim;
	logic [dtp_pkg::DAYS_W-1:0]  ybase;
	logic [dtp_pkg::LEAP_W-1:0]  leaps;
	logic [dtp_pkg::MOFF_W-1:0]  moff;
	logic                        ok3;
	logic [dtp_pkg::DAYS_W-1:0]  days;

	// Each stage moves when it is empty or the stage after it moves.
	assign rdy4     = !v4_s4 || out_ready;
	assign rdy3     = !v3_s3 || rdy4;
	assign rdy2     = !v2_s2 || rdy3;
	assign rdy1     = !v1_s1 || rdy2;
	assign in_ready = rdy1;

	// Stage 2: year divided by 100 through the reciprocal.
	always_comb begin
		prod = dtp_pkg::PROD_W'(date_s1.year) * dtp_pkg::PROD_W'(dtp_pkg::DIV100_MUL);
	end

	// Stage 3: leap rule, day bound, whole years and month offset.
	always_comb begin
		cent_mul    = dtp_pkg::YEAR_W'(quot_s2) * dtp_pkg::YEAR_W'(dtp_pkg::CENTURY);
		rem_zero    = date_s2.year == cent_mul;
		leap        = ((date_s2.year[1:0] == 2'd0) && !rem_zero)
			|| (rem_zero && (quot_s2[1:0] == 2'd0));
		// The year before has one century fewer when this year is a whole century.
		quot_prev   = quot_s2 - dtp_pkg::QUOT_W'(rem_zero);
		year_prev   = date_s2.year - dtp_pkg::YEAR_W'(1);
		after_epoch = date_s2.year > dtp_pkg::YEAR_W'(dtp_pkg::EPOCH_YEAR);

		dim = dtp_pkg::month_len(date_s2.month)
			+ dtp_pkg::DAY_W'(leap && (date_s2.month == dtp_pkg::MONTH_FEB));
		ok3 = date_s2.ok && (date_s2.day <= dim);

		if (after_epoch) begin
			ybase = dtp_pkg::DAYS_W'(dtp_pkg::DAYS_PER_YEAR)
				* dtp_pkg::DAYS_W'(date_s2.year - dtp_pkg::YEAR_W'(dtp_pkg::EPOCH_YEAR));
			leaps = dtp_pkg::LEAP_W'(year_prev >> 2)
				- dtp_pkg::LEAP_W'(quot_prev)
				+ dtp_pkg::LEAP_W'(quot_prev >> 2)
				- dtp_pkg::LEAP_W'(dtp_pkg::LEAPS_BEFORE_EPOCH);
		end else begin
			ybase = '0;
			leaps = '0;
		end

		moff = dtp_pkg::month_start(date_s2.month)
			+ dtp_pkg::MOFF_W'(leap && (date_s2.month > dtp_pkg::MONTH_FEB));
	end

	// Stage 4: final sum.
	always_comb begin
		days = ybase_s3 + dtp_pkg::DAYS_W'(leaps_s3) + dtp_pkg::DAYS_W'(moff_s3)
			+ dtp_pkg::DAYS_W'(date_s3.day) - dtp_pkg::DAYS_W'(1);
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
		end else begin
			if (rdy1) begin
				v1_s1 <= in_valid;
			end
			if (rdy2) begin
				v2_s2 <= v1_s1;
			end
			if (rdy3) begin
				v3_s3 <= v2_s2;
			end
			if (rdy4) begin
				v4_s4 <= v3_s3;
			end
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			date_s1 <= in_date;
		end
		if (rdy2 && v1_s1) begin
			date_s2 <= date_s1;
			quot_s2 <= prod[dtp_pkg::DIV100_SHIFT +: dtp_pkg::QUOT_W];
		end
		if (rdy3 && v2_s2) begin
			date_s3    <= {ok3, date_s2.year, date_s2.month, date_s2.day};
			ybase_s3   <= ybase;
			leaps_s3   <= leaps;
			moff_s3    <= moff;
		end
		if (rdy4 && v3_s3) begin
			if (date_s3.ok) begin
				date_s4 <= date_s3;
				days_s4 <= days;
			end else begin
				date_s4 <= '0;
				days_s4 <= '0;
			end
		end
	end

	assign out_valid = v4_s4;
	assign out_date  = date_s4;
	assign out_days  = days_s4;

endmodule
